>>> hw/rtl/sync_frame_checker_macros.svh
// ----------------------------------------------------------------------------
// sync_frame_checker assertion macros
// Shared assertion forms for the frame checker checkers.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_CHECKER_MACROS_SVH
`define SYNC_FRAME_CHECKER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Types and constants shared by the sync frame checker modules.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam logic [7:0]  HDR_FIRST    = 8'hA5;
    localparam logic [7:0]  HDR_SECOND   = 8'h5A;
    // XOR of the two header bytes, seeds the checksum walk
    localparam logic [7:0]  XOR_SEED     = 8'hFF;
    localparam logic [31:0] WARMUP_RESET = 32'd100000;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        HUNT_FIRST   = 3'b001,
        HUNT_SECOND  = 3'b010,
        HUNT_COLLECT = 3'b100
    } hunt_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_TALLY = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    typedef struct packed {
        logic [7:0] id;
        logic       ok;
        logic       bad;
    } walk_res_t;

endpackage

>>> hw/rtl/sfc_if.sv
// ----------------------------------------------------------------------------
// sfc_if
// Valid/ready channels for received words and frame reports.
// ----------------------------------------------------------------------------
interface sfc_byte_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sfc_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_id;
    logic        checksum_ok;
    logic        sequence_gap;
    logic        pattern_bad;
    logic [31:0] total_frames;
    logic [31:0] checksum_errors;
    logic [31:0] gap_errors;
    logic [31:0] pattern_errors;

    modport source (
        output valid, output frame_id, output checksum_ok, output sequence_gap,
        output pattern_bad, output total_frames, output checksum_errors,
        output gap_errors, output pattern_errors, input ready
    );
    modport sink (
        input valid, input frame_id, input checksum_ok, input sequence_gap,
        input pattern_bad, input total_frames, input checksum_errors,
        input gap_errors, input pattern_errors, output ready
    );
endinterface

>>> hw/rtl/sfc_frame_walker.sv
// ----------------------------------------------------------------------------
// sfc_frame_walker
// Frame store plus a sequenced walk that folds the checksum, picks up the
// id and checks the payload pattern one stored byte per cycle.
// ----------------------------------------------------------------------------
module sfc_frame_walker #(
    parameter int FRAME_BYTES = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
    input  logic [7:0]                     wr_data,
    input  logic                           start,
    output sfc_pkg::walk_res_t             res,
    output logic                           done
);
    import sfc_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] LAST    = AW'(FRAME_BYTES - 1);
    localparam logic [AW-1:0] POS_ID  = AW'(2);
    localparam logic [AW-1:0] POS_CHK = AW'(3);

    logic [7:0]    mem [FRAME_BYTES];
    logic [7:0]    rd_data_reg;

    logic          busy_reg;
    logic [AW-1:0] addr_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] pos_reg;
    logic          done_reg;

    logic [7:0]    xor_reg;
    logic [7:0]    chk_reg;
    logic [7:0]    id_reg;
    logic [7:0]    pat_reg;
    logic          bad_reg;

    // header bytes are never stored; their XOR is the seed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
            pos_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else if (start)
        begin
            busy_reg   <= 1'b1;
            addr_reg   <= POS_ID;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= busy_reg;
            pos_reg    <= addr_reg;
            done_reg   <= rd_vld_reg && (pos_reg == LAST);
            if (busy_reg)
            begin
                if (addr_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    addr_reg <= addr_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xor_reg <= XOR_SEED;
            bad_reg <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (pos_reg == POS_ID)
            begin
                id_reg  <= rd_data_reg;
                pat_reg <= rd_data_reg;
                xor_reg <= xor_reg ^ rd_data_reg;
            end
            else if (pos_reg == POS_CHK)
            begin
                chk_reg <= rd_data_reg;
            end
            else
            begin
                xor_reg <= xor_reg ^ rd_data_reg;
                pat_reg <= pat_reg + 8'd1;
                if (rd_data_reg != pat_reg)
                begin
                    bad_reg <= 1'b1;
                end
            end
        end
    end

    assign res.id  = id_reg;
    assign res.ok  = (xor_reg == chk_reg);
    assign res.bad = bad_reg;
    assign done    = done_reg;

endmodule

>>> hw/rtl/sync_frame_checker.sv
// ----------------------------------------------------------------------------
// sync_frame_checker
// Hunts received words for the header A5 5A, collects FRAME_BYTES-byte
// frames and reports checksum, sequence and payload-pattern outcomes with
// four wrapping 32-bit error/frame counters.
// Channels: byte_ch takes words (kind 0 = data byte, kind 1 = clear counters
// and expected id); result_ch gives one report per completed frame.
// cfg_wr_en/cfg_wr_data write warmup_frames; write only while idle.
// byte_ch.ready is high only while idle: after the last byte of a frame it
// stays low while the walker reads the frame store one byte per cycle
// (single read port) and through the tally and output states.
// The walk result is tallied, then loaded into the output register.
// The report sits in an output register; further words are taken while it
// waits, and only the next frame end stalls until result_ch takes it.
// Reset clears the hunt, counters and expected id; warmup is 100000.
// ----------------------------------------------------------------------------
module sync_frame_checker #(
    parameter int FRAME_BYTES = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    sfc_byte_if.sink     byte_ch,
    sfc_result_if.source result_ch,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data
);
    import sfc_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] LAST   = AW'(FRAME_BYTES - 1);
    localparam logic [AW-1:0] POS_ID = AW'(2);

    state_t        state_reg;
    hunt_t         hunt_reg;
    logic [AW-1:0] pos_reg;
    logic [31:0]   warmup_reg;
    logic [7:0]    expected_reg;
    logic [31:0]   frame_count_reg;
    logic [31:0]   chk_fail_reg;
    logic [31:0]   gap_count_reg;
    logic [31:0]   pat_fail_reg;
    logic          warm_reg;
    walk_res_t     res_reg;
    logic          gap_reg;
    logic          bad_reg;
    logic          out_valid_reg;

    logic          in_fire;
    logic          byte_fire;
    logic          wr_en;
    logic          start;
    walk_res_t     walk_res;
    logic          walk_done;
    logic [7:0]    exp_eff;
    logic          gap_c;
    logic          bad_c;
    logic          out_load;

    assign byte_ch.ready = (state_reg == ST_IDLE);
    assign in_fire       = byte_ch.valid && byte_ch.ready;
    assign byte_fire     = in_fire && (byte_ch.kind == KIND_BYTE);
    assign wr_en         = byte_fire && (hunt_reg == HUNT_COLLECT);
    assign start         = wr_en && (pos_reg == LAST);

    // expected id is replaced by the received one during warm-up
    assign exp_eff  = warm_reg ? res_reg.id : expected_reg;
    assign gap_c    = res_reg.ok && (res_reg.id != exp_eff);
    assign bad_c    = res_reg.ok && res_reg.bad;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || result_ch.ready);

    sfc_frame_walker #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (byte_ch.data_byte),
        .start   (start),
        .res     (walk_res),
        .done    (walk_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            hunt_reg        <= HUNT_FIRST;
            pos_reg         <= '0;
            warmup_reg      <= WARMUP_RESET;
            expected_reg    <= '0;
            frame_count_reg <= '0;
            chk_fail_reg    <= '0;
            gap_count_reg   <= '0;
            pat_fail_reg    <= '0;
            warm_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                warmup_reg <= cfg_wr_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (byte_ch.kind == KIND_CLEAR))
                    begin
                        frame_count_reg <= '0;
                        chk_fail_reg    <= '0;
                        gap_count_reg   <= '0;
                        pat_fail_reg    <= '0;
                        expected_reg    <= '0;
                    end
                    else if (byte_fire)
                    begin
                        case (hunt_reg)
                            HUNT_FIRST:
                            begin
                                if (byte_ch.data_byte == HDR_FIRST)
                                begin
                                    hunt_reg <= HUNT_SECOND;
                                end
                            end
                            HUNT_SECOND:
                            begin
                                if (byte_ch.data_byte == HDR_SECOND)
                                begin
                                    hunt_reg <= HUNT_COLLECT;
                                    pos_reg  <= POS_ID;
                                end
                                else
                                begin
                                    hunt_reg <= HUNT_FIRST;
                                end
                            end
                            HUNT_COLLECT:
                            begin
                                if (pos_reg == LAST)
                                begin
                                    hunt_reg  <= HUNT_FIRST;
                                    pos_reg   <= '0;
                                    state_reg <= ST_WALK;
                                end
                                else
                                begin
                                    pos_reg <= pos_reg + AW'(1);
                                end
                            end
                            default:
                            begin
                                hunt_reg <= HUNT_FIRST;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    warm_reg <= (frame_count_reg < warmup_reg);
                    if (walk_done)
                    begin
                        state_reg <= ST_TALLY;
                    end
                end
                ST_TALLY:
                begin
                    frame_count_reg <= frame_count_reg + 32'd1;
                    chk_fail_reg    <= chk_fail_reg + {31'd0, !res_reg.ok};
                    gap_count_reg   <= gap_count_reg + {31'd0, gap_c};
                    pat_fail_reg    <= pat_fail_reg + {31'd0, bad_c};
                    expected_reg    <= res_reg.id + 8'd1;
                    state_reg       <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_done)
        begin
            res_reg <= walk_res;
        end
        if (state_reg == ST_TALLY)
        begin
            gap_reg <= gap_c;
            bad_reg <= bad_c;
        end
        if (out_load)
        begin
            result_ch.frame_id        <= res_reg.id;
            result_ch.checksum_ok     <= res_reg.ok;
            result_ch.sequence_gap    <= gap_reg;
            result_ch.pattern_bad     <= bad_reg;
            result_ch.total_frames    <= frame_count_reg;
            result_ch.checksum_errors <= chk_fail_reg;
            result_ch.gap_errors      <= gap_count_reg;
            result_ch.pattern_errors  <= pat_fail_reg;
        end
    end

    assign result_ch.valid = out_valid_reg;

endmodule

>>> hw/rtl/sfc_checker.sv
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks for sync_frame_checker, attached by bind.
// ----------------------------------------------------------------------------
`include "sync_frame_checker_macros.svh"

module sfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  frame_id,
    input logic        checksum_ok,
    input logic        sequence_gap,
    input logic        pattern_bad,
    input logic [31:0] total_frames,
    input logic [31:0] checksum_errors,
    input logic [31:0] gap_errors,
    input logic [31:0] pattern_errors
);
    import sfc_pkg::*;

    // a stalled report holds
    `SFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_id) && $stable(total_frames), "stalled report changed")

    // failed checksum suppresses the other checks and was counted
    `SFC_ASSERT_NOW(a_chk_fail, out_valid && !checksum_ok, !sequence_gap && !pattern_bad && (checksum_errors != 32'd0), "checksum failure report inconsistent")

    // a flagged error is already in its counter
    `SFC_ASSERT_NOW(a_flag_count, out_valid && (sequence_gap || pattern_bad), (!sequence_gap || (gap_errors != 32'd0)) && (!pattern_bad || (pattern_errors != 32'd0)), "flag without counted error")

    // a clear word never starts a frame walk
    `SFC_ASSERT_NEXT(a_clear_ready, in_valid && in_ready && (in_kind == KIND_CLEAR), in_ready, "ready dropped after clear")

endmodule

bind sync_frame_checker sfc_checker u_sfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (byte_ch.valid),
    .in_ready        (byte_ch.ready),
    .in_kind         (byte_ch.kind),
    .out_valid       (result_ch.valid),
    .out_ready       (result_ch.ready),
    .frame_id        (result_ch.frame_id),
    .checksum_ok     (result_ch.checksum_ok),
    .sequence_gap    (result_ch.sequence_gap),
    .pattern_bad     (result_ch.pattern_bad),
    .total_frames    (result_ch.total_frames),
    .checksum_errors (result_ch.checksum_errors),
    .gap_errors      (result_ch.gap_errors),
    .pattern_errors  (result_ch.pattern_errors)
);
